/* design/jse_pkg.sv */
// shared types, constants and character helpers of the json string escaper
package jse_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_TWO    = 8'h32;
  localparam logic [7:0] CH_EIGHT  = 8'h38;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_HEX_AF = 8'h57;
  localparam logic [7:0] CTRL_MAX  = 8'h1f;
  localparam logic [7:0] BYTE_E2   = 8'he2;
  localparam logic [7:0] BYTE_80   = 8'h80;
  localparam logic [7:0] BYTE_A8   = 8'ha8;
  localparam logic [7:0] BYTE_A9   = 8'ha9;

  localparam logic [1:0] HOLD_NONE  = 2'd0;
  localparam logic [1:0] HOLD_E2    = 2'd1;
  localparam logic [1:0] HOLD_E2_80 = 2'd2;

  localparam int unsigned NUM_SLOTS = 12;
  localparam int unsigned SLOT_W    = 4;
  localparam logic [SLOT_W-1:0] SLOT_OPEN  = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_PRE0  = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_PRE1  = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_BODY  = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_POST0 = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_POST1 = 4'd10;
  localparam logic [SLOT_W-1:0] SLOT_CLOSE = 4'd11;

  typedef enum logic [2:0] {
    BODY_NONE  = 3'd0,
    BODY_PLAIN = 3'd1,
    BODY_SHORT = 3'd2,
    BODY_UHEX  = 3'd3,
    BODY_ULS   = 3'd4
  } body_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       first_char;
    logic       final_char;
    logic       no_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_item_t;

  // one accepted item, reduced to the pieces that the back end expands
  typedef struct packed {
    logic       open;
    logic [1:0] pre_flush;
    body_e      body;
    logic [7:0] body_byte;
    logic [1:0] post_flush;
    logic       close;
  } plan_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] short_char(input logic [7:0] c);
    logic [7:0] s;
    case (c)
      8'h5c: s = CH_BSLASH;
      8'h22: s = CH_QUOTE;
      8'h08: s = 8'h62;
      8'h0c: s = 8'h66;
      8'h0a: s = 8'h6e;
      8'h0d: s = 8'h72;
      8'h09: s = 8'h74;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] d;
    if (n < 4'd10) begin
      d = CH_ZERO + {4'd0, n};
    end else begin
      d = CH_HEX_AF + {4'd0, n};
    end
    return d;
  endfunction

  function automatic logic [2:0] body_len(input body_e kind);
    logic [2:0] len;
    case (kind)
      BODY_PLAIN: len = 3'd1;
      BODY_SHORT: len = 3'd2;
      BODY_UHEX:  len = 3'd6;
      BODY_ULS:   len = 3'd6;
      default:    len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] body_char(input body_e kind, input logic [7:0] b,
                                           input logic [2:0] idx);
    logic [7:0] ch;
    ch = b;
    case (kind)
      BODY_SHORT: begin
        if (idx == 3'd0) begin
          ch = CH_BSLASH;
        end
      end
      BODY_UHEX: begin
        case (idx)
          3'd0: ch = CH_BSLASH;
          3'd1: ch = CH_U;
          3'd2: ch = CH_ZERO;
          3'd3: ch = CH_ZERO;
          3'd4: ch = hex_digit(b[7:4]);
          default: ch = hex_digit(b[3:0]);
        endcase
      end
      BODY_ULS: begin
        case (idx)
          3'd0: ch = CH_BSLASH;
          3'd1: ch = CH_U;
          3'd2: ch = CH_TWO;
          3'd3: ch = CH_ZERO;
          3'd4: ch = CH_TWO;
          default: ch = (b == BYTE_A8) ? CH_EIGHT : CH_NINE;
        endcase
      end
      default: ch = b;
    endcase
    return ch;
  endfunction

endpackage

/* design/jse_front.sv */
// front end: accepts bytes, tracks held utf-8 prefixes and builds one plan per item
module jse_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jse_pkg::in_item_t  in_data_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  input  jse_pkg::q_stat_t   q_stat_i,
  output logic               push_o,
  output jse_pkg::plan_t     plan_o
);
  import jse_pkg::*;

  logic [1:0] hold_q, hold_d;
  logic       enable_q;
  logic       accept;
  logic [1:0] hs;
  logic       done;
  logic [7:0] sc;
  plan_t      plan;

  assign in_ready_o  = !q_stat_i.full;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    hs   = (hold_q == HOLD_E2 || hold_q == HOLD_E2_80) ? hold_q : HOLD_NONE;
    done = 1'b0;
    sc   = short_char(in_data_i.char_code);
    plan = '{open: 1'b0, pre_flush: 2'd0, body: BODY_NONE, body_byte: in_data_i.char_code,
             post_flush: 2'd0, close: 1'b0};
    if (in_data_i.first_char) begin
      plan.open = 1'b1;
      hs        = HOLD_NONE;
    end
    if (!in_data_i.no_char) begin
      if (hs == HOLD_E2_80) begin
        if (in_data_i.char_code == BYTE_A8 || in_data_i.char_code == BYTE_A9) begin
          plan.body = BODY_ULS;
          done      = 1'b1;
        end else begin
          plan.pre_flush = 2'd2;
        end
        hs = HOLD_NONE;
      end else if (hs == HOLD_E2) begin
        if (in_data_i.char_code == BYTE_80) begin
          hs   = HOLD_E2_80;
          done = 1'b1;
        end else begin
          plan.pre_flush = 2'd1;
          hs             = HOLD_NONE;
        end
      end
      if (!done) begin
        if (in_data_i.char_code == BYTE_E2) begin
          hs = HOLD_E2;
        end else if (sc != 8'h00) begin
          plan.body      = BODY_SHORT;
          plan.body_byte = sc;
        end else if (in_data_i.char_code <= CTRL_MAX) begin
          plan.body = BODY_UHEX;
        end else begin
          plan.body = BODY_PLAIN;
        end
      end
    end
    if (in_data_i.final_char) begin
      plan.post_flush = hs;
      plan.close      = 1'b1;
      hs              = HOLD_NONE;
    end
    hold_d = hold_q;
    push_o = 1'b0;
    if (accept) begin
      if (enable_q) begin
        hold_d = hs;
        push_o = plan.open || (plan.pre_flush != 2'd0) || (plan.body != BODY_NONE) ||
                 (plan.post_flush != 2'd0) || plan.close;
      end else begin
        hold_d = HOLD_NONE;
      end
    end
  end

  assign plan_o = plan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= HOLD_NONE;
      enable_q <= 1'b1;
    end else begin
      hold_q <= hold_d;
      if (cfg_valid_i && cfg_ready_o) begin
        enable_q <= cfg_data_i;
      end
    end
  end

endmodule

/* design/jse_queue.sv */
// short plan queue between the front and back ends
module jse_queue #(
  parameter int unsigned Depth = jse_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jse_pkg::plan_t    plan_i,
  input  logic              pop_i,
  output jse_pkg::plan_t    head_o,
  output jse_pkg::q_stat_t  stat_o
);
  import jse_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  plan_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= plan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

/* design/jse_back.sv */
// back end: walks the output slots of the head plan, one character per transfer
module jse_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  jse_pkg::plan_t     head_i,
  input  jse_pkg::q_stat_t   q_stat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jse_pkg::out_item_t out_data_o
);
  import jse_pkg::*;

  logic [SLOT_W-1:0]    pos_q, pos_d, cur;
  logic [NUM_SLOTS-1:0] slot_vec, mask, rest;
  logic [2:0]           blen;
  logic [7:0]           ch;
  logic                 last, load;
  logic                 out_valid_q;
  out_item_t            out_q;

  always_comb begin
    blen     = body_len(head_i.body);
    slot_vec = '0;
    slot_vec[SLOT_OPEN]  = head_i.open;
    slot_vec[SLOT_PRE0]  = (head_i.pre_flush != 2'd0);
    slot_vec[SLOT_PRE1]  = (head_i.pre_flush == 2'd2);
    for (int i = 0; i < 6; i++) begin
      slot_vec[int'(SLOT_BODY) + i] = (3'(i) < blen);
    end
    slot_vec[SLOT_POST0] = (head_i.post_flush != 2'd0);
    slot_vec[SLOT_POST1] = (head_i.post_flush == 2'd2);
    slot_vec[SLOT_CLOSE] = head_i.close;

    mask = slot_vec & ~((NUM_SLOTS'(1) << pos_q) - NUM_SLOTS'(1));
    cur  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        cur = SLOT_W'(i);
      end
    end
    rest      = mask;
    rest[cur] = 1'b0;
    last      = (rest == '0);

    case (cur)
      SLOT_OPEN:  ch = CH_QUOTE;
      SLOT_PRE0:  ch = BYTE_E2;
      SLOT_PRE1:  ch = BYTE_80;
      SLOT_POST0: ch = BYTE_E2;
      SLOT_POST1: ch = BYTE_80;
      SLOT_CLOSE: ch = CH_QUOTE;
      default:    ch = body_char(head_i.body, head_i.body_byte, 3'(cur - SLOT_BODY));
    endcase

    load  = !q_stat_i.empty && (!out_valid_q || out_ready_i);
    pop_o = load && last;
    pos_d = pos_q;
    if (load) begin
      pos_d = last ? '0 : cur + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= '{out_char: ch, last_of_run: last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/json_string_escaper_unit.sv */
// top level of the json string escaper
// Takes a string one byte per transfer and emits its quoted, escaped JSON
// form one character per transfer, with last_of_run on the final character
// of each input item. Plain text streams at one byte per cycle while the
// receiver keeps out_ready_i high; an item that expands to n characters
// occupies the output port for n transfers, which is what sets the rate,
// and the input stalls once the plan queue (QueueDepth entries) is full.
// An accepted item goes through the plan queue and then the output register.
// Bytes E2 and E2 80 are held back until the next byte decides; an item with
// no output (a held byte, or any item while output_enable is 0) is not queued.
module json_string_escaper_unit #(
  parameter int unsigned QueueDepth = jse_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  jse_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output jse_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import jse_pkg::*;

  logic    push, pop;
  plan_t   plan, head;
  q_stat_t q_stat;

  jse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .plan_o      (plan)
  );

  jse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .plan_i (plan),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty plan queue");

  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o && out_data_o.last_of_run)
    else $error("plan retired without last_of_run on its final character");

  a_out_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!q_stat.empty))
    else $error("output appeared with no queued plan");

endmodule

/* test/json_string_escaper_unit_checker.sv */
// checker of the json string escaper: predicts the characters of each input transfer and compares
`timescale 1ns / 1ps

module json_string_escaper_unit_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  jse_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  jse_pkg::out_item_t out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_data_i,
  output int                 mismatch_count_o,
  output int                 pending_o
);
  import jse_pkg::*;

  localparam int unsigned MAX_RUN = 9;

  localparam logic [7:0] CTRL_BS   = 8'h08;
  localparam logic [7:0] CTRL_TAB  = 8'h09;
  localparam logic [7:0] CTRL_LF   = 8'h0a;
  localparam logic [7:0] CTRL_FF   = 8'h0c;
  localparam logic [7:0] CTRL_CR   = 8'h0d;
  localparam logic [7:0] ESC_B     = 8'h62;
  localparam logic [7:0] ESC_F     = 8'h66;
  localparam logic [7:0] ESC_N     = 8'h6e;
  localparam logic [7:0] ESC_R     = 8'h72;
  localparam logic [7:0] ESC_T     = 8'h74;
  localparam logic [7:0] NO_SHORT  = 8'h00;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  logic [1:0] held_stage;
  logic       enable_q;
  logic [7:0] run_buf [MAX_RUN];
  int         run_len;
  out_item_t  expected_chars [$];

  function automatic logic [7:0] nibble_char(input logic [3:0] v);
    if (v < 4'd10) begin
      return CH_ZERO + {4'h0, v};
    end
    return CH_LOWER_A + {4'h0, v} - 8'd10;
  endfunction

  task automatic put_char(input logic [7:0] c);
    if (run_len < MAX_RUN) begin
      run_buf[run_len] = c;
      run_len++;
    end
  endtask

  task automatic put_uescape(input logic [7:0] d0, input logic [7:0] d1,
                             input logic [7:0] d2, input logic [7:0] d3);
    put_char(CH_BSLASH);
    put_char(CH_U);
    put_char(d0);
    put_char(d1);
    put_char(d2);
    put_char(d3);
  endtask

  task automatic release_held();
    if (held_stage == HOLD_E2) begin
      put_char(BYTE_E2);
    end else if (held_stage == HOLD_E2_80) begin
      put_char(BYTE_E2);
      put_char(BYTE_80);
    end
    held_stage = HOLD_NONE;
  endtask

  task automatic escape_byte(input logic [7:0] c);
    logic [7:0] tag;
    case (c)
      CH_BSLASH: tag = CH_BSLASH;
      CH_QUOTE:  tag = CH_QUOTE;
      CTRL_BS:   tag = ESC_B;
      CTRL_FF:   tag = ESC_F;
      CTRL_LF:   tag = ESC_N;
      CTRL_CR:   tag = ESC_R;
      CTRL_TAB:  tag = ESC_T;
      default:   tag = NO_SHORT;
    endcase
    if (tag != NO_SHORT) begin
      put_char(CH_BSLASH);
      put_char(tag);
    end else if (c <= CTRL_MAX) begin
      put_uescape(CH_ZERO, CH_ZERO, nibble_char(c[7:4]), nibble_char(c[3:0]));
    end else begin
      put_char(c);
    end
  endtask

  task automatic escape_item(input in_item_t it);
    logic      matched;
    out_item_t ch;
    run_len = 0;
    if (held_stage > HOLD_E2_80) begin
      held_stage = HOLD_NONE;
    end
    if (!enable_q) begin
      held_stage = HOLD_NONE;
      return;
    end
    if (it.first_char) begin
      held_stage = HOLD_NONE;
      put_char(CH_QUOTE);
    end
    if (!it.no_char) begin
      matched = 1'b0;
      if (held_stage == HOLD_E2_80 &&
          (it.char_code == BYTE_A8 || it.char_code == BYTE_A9)) begin
        put_uescape(CH_TWO, CH_ZERO, CH_TWO,
                    (it.char_code == BYTE_A8) ? CH_EIGHT : CH_NINE);
        held_stage = HOLD_NONE;
        matched = 1'b1;
      end else if (held_stage == HOLD_E2 && it.char_code == BYTE_80) begin
        held_stage = HOLD_E2_80;
        matched = 1'b1;
      end else begin
        release_held();
      end
      if (!matched) begin
        if (it.char_code == BYTE_E2) begin
          held_stage = HOLD_E2;
        end else begin
          escape_byte(it.char_code);
        end
      end
    end
    if (it.final_char) begin
      release_held();
      put_char(CH_QUOTE);
    end
    for (int k = 0; k < run_len; k++) begin
      ch.out_char    = run_buf[k];
      ch.last_of_run = (k == run_len - 1);
      expected_chars.push_back(ch);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      held_stage = HOLD_NONE;
      enable_q   = 1'b1;
      expected_chars.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_chars.size() == 0) begin
          $error("out_char: expected nothing, got %h", out_data_i.out_char);
          mismatch_count_o++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data_i.out_char !== want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, out_data_i.out_char);
            mismatch_count_o++;
          end
          if (out_data_i.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %b, got %b", want.last_of_run,
                   out_data_i.last_of_run);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        enable_q = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) begin
        escape_item(in_data_i);
      end
      pending_o <= expected_chars.size();
    end
  end

endmodule

/* test/json_string_escaper_unit_tb.sv */
// testbench top of the json string escaper: stimulus, idling and verdict
`timescale 1ns / 1ps

module json_string_escaper_unit_tb;
  import jse_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b1;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i  = 1'b1;

  int         mismatches;
  int         pending;
  int         cycle_count = 0;
  int         sent_count  = 0;
  int         stall_left  = 0;
  logic       idle_on     = 1'b1;
  logic       enabled_now = 1'b1;
  logic       mid_done    = 1'b0;
  logic [7:0] text_q [$];

  json_string_escaper_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  json_string_escaper_unit_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_i       (out_data_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stalls in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 12);
    end
    out_ready_i <= (stall_left == 0);
  end

  function automatic in_item_t make_item(input logic [7:0] c, input logic f,
                                         input logic l, input logic n);
    in_item_t it;
    it.char_code  = c;
    it.first_char = f;
    it.final_char = l;
    it.no_char    = n;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (enabled_now) begin
      sent_count++;
    end
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic set_output_enable(input logic en);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    // held bytes yield no characters, so let the pipe settle
    repeat (4) @(posedge clk_i);
    cfg_data_i  <= en;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    enabled_now = en;
  endtask

  task automatic send_string();
    int   form;
    logic opened;
    logic closed;
    text_q.delete();
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 9))
        0: begin
          text_q.push_back(BYTE_E2);
          text_q.push_back(BYTE_80);
          text_q.push_back($urandom_range(0, 1) ? BYTE_A9 : BYTE_A8);
        end
        1: begin
          text_q.push_back(BYTE_E2);
          if ($urandom_range(0, 1)) begin
            text_q.push_back(BYTE_80);
          end
          text_q.push_back(8'($urandom_range(0, 255)));
        end
        2: text_q.push_back(8'($urandom_range(0, 31)));
        3: text_q.push_back($urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
        4, 5: text_q.push_back(8'($urandom_range(0, 255)));
        default: text_q.push_back(8'($urandom_range(32, 126)));
      endcase
    end
    form   = $urandom_range(0, 9);
    opened = (form != 8) || $urandom_range(0, 1);
    closed = (form != 8) || $urandom_range(0, 1);
    if (text_q.size() == 0) begin
      send_item(make_item(8'($urandom_range(0, 255)), opened, closed, 1'b1));
    end else begin
      foreach (text_q[i]) begin
        if ($urandom_range(0, 11) == 0) begin
          send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1));
        end
        if (form == 9) begin
          send_item(make_item(text_q[i], 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)),
                              $urandom_range(0, 3) == 0));
        end else begin
          send_item(make_item(text_q[i], opened && i == 0,
                              closed && i == text_q.size() - 1, 1'b0));
        end
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // plain, short escapes, control bytes and the extremes
    send_item(make_item(8'h61, 1'b1, 1'b0, 1'b0));
    send_item(make_item(8'h00, 1'b0, 1'b0, 1'b0));
    send_item(make_item(8'h1f, 1'b0, 1'b0, 1'b0));
    send_item(make_item(8'h08, 1'b0, 1'b0, 1'b0));
    send_item(make_item(8'h0c, 1'b0, 1'b0, 1'b0));
    send_item(make_item(8'h0a, 1'b0, 1'b0, 1'b0));
    send_item(make_item(8'h0d, 1'b0, 1'b0, 1'b0));
    send_item(make_item(8'h09, 1'b0, 1'b0, 1'b0));
    send_item(make_item(CH_BSLASH, 1'b0, 1'b0, 1'b0));
    send_item(make_item(CH_QUOTE, 1'b0, 1'b0, 1'b0));
    send_item(make_item(8'hff, 1'b0, 1'b0, 1'b0));
    // line and paragraph separators
    send_item(make_item(BYTE_E2, 1'b0, 1'b0, 1'b0));
    send_item(make_item(BYTE_80, 1'b0, 1'b0, 1'b0));
    send_item(make_item(BYTE_A8, 1'b0, 1'b0, 1'b0));
    send_item(make_item(BYTE_E2, 1'b0, 1'b0, 1'b0));
    send_item(make_item(BYTE_80, 1'b0, 1'b0, 1'b0));
    send_item(make_item(BYTE_A9, 1'b0, 1'b0, 1'b0));
    // broken sequences flush the held bytes
    send_item(make_item(BYTE_E2, 1'b0, 1'b0, 1'b0));
    send_item(make_item(8'h41, 1'b0, 1'b0, 1'b0));
    send_item(make_item(BYTE_E2, 1'b0, 1'b0, 1'b0));
    send_item(make_item(BYTE_80, 1'b0, 1'b0, 1'b0));
    send_item(make_item(8'h00, 1'b0, 1'b0, 1'b1));
    send_item(make_item(8'h42, 1'b0, 1'b1, 1'b0));
    // opening quote drops held bytes, closing quote flushes them
    send_item(make_item(BYTE_E2, 1'b0, 1'b0, 1'b0));
    send_item(make_item(8'h7e, 1'b1, 1'b0, 1'b0));
    send_item(make_item(BYTE_E2, 1'b0, 1'b1, 1'b0));
    send_item(make_item(8'hff, 1'b1, 1'b1, 1'b1));
    send_item(make_item(8'h10, 1'b0, 1'b1, 1'b0));

    // disabled items clear the held bytes
    send_item(make_item(BYTE_E2, 1'b1, 1'b0, 1'b0));
    send_item(make_item(BYTE_80, 1'b0, 1'b0, 1'b0));
    set_output_enable(1'b0);
    send_item(make_item(8'h41, 1'b1, 1'b0, 1'b0));
    send_item(make_item(BYTE_A8, 1'b0, 1'b0, 1'b0));
    send_item(make_item(8'hff, 1'b0, 1'b1, 1'b0));
    send_item(make_item(8'h00, 1'b1, 1'b1, 1'b1));
    set_output_enable(1'b1);
    send_item(make_item(BYTE_A8, 1'b0, 1'b1, 1'b0));

    sent_count = 0;
    while (sent_count < 325) begin
      idle_on <= (sent_count < 270) && ($urandom_range(0, 3) != 0);
      if (!mid_done && sent_count >= 160) begin
        mid_done = 1'b1;
        set_output_enable(1'b0);
        repeat (12) begin
          send_item(make_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
        set_output_enable(1'b1);
      end
      send_string();
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
